FILE: hw/rtl/cth_pkg.sv
// ----------------------------------------------------------------------------
// cth_pkg
// Shared constants and types of the call trace hash aggregator.
// ----------------------------------------------------------------------------
package cth_pkg;

   localparam int unsigned TABLE_SIZE_DEF  = 4096;
   localparam int unsigned FRAME_DEPTH_DEF = 16384;
   localparam int unsigned STACK_DEPTH_DEF = 128;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   typedef struct packed {
      logic [63:0] frame_method;
      logic signed [31:0] frame_bci;
      logic [31:0] sample_weight;
      logic [7:0]  trace_length;
      logic        last_frame;
   } req_type;

   typedef struct packed {
      logic [11:0] trace_slot;
      logic        new_entry;
      logic        frames_dropped;
      logic        table_full;
   } rsp_type;

endpackage

FILE: hw/rtl/cth_if.sv
// ----------------------------------------------------------------------------
// cth_req_if / cth_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface cth_req_if;
   logic             valid;
   logic             ready;
   cth_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cth_rsp_if;
   logic             valid;
   logic             ready;
   cth_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cth_mul64.sv
// ----------------------------------------------------------------------------
// cth_mul64
// Low 64 bits of a product with the mixing constant: three registered 32x32
// partial products summed after the register, so p follows a in the next cycle.
// ----------------------------------------------------------------------------
module cth_mul64 (
   input  logic        clock,
   input  logic [63:0] a,
   output logic [63:0] p
);
   localparam logic [31:0] ML = cth_pkg::MIX_MUL[31:0];
   localparam logic [31:0] MH = cth_pkg::MIX_MUL[63:32];

   logic [63:0] ll_ff;
   logic [31:0] lh_ff, hl_ff;

   always_ff @(posedge clock) begin
      ll_ff <= {32'd0, a[31:0]} * {32'd0, ML};
      lh_ff <= a[31:0] * MH;
      hl_ff <= a[63:32] * ML;
   end

   assign p = ll_ff + {lh_ff + hl_ff, 32'd0};
endmodule

FILE: hw/rtl/cth_table.sv
// ----------------------------------------------------------------------------
// cth_table
// Slot memory: hash, counters, arena start and length, one entry per slot,
// one synchronous read port and one write port.
// ----------------------------------------------------------------------------
module cth_table #(
   parameter int unsigned TABLE_SIZE = cth_pkg::TABLE_SIZE_DEF,
   parameter int unsigned SW = 15,
   parameter int unsigned LW = 8,
   localparam int unsigned AW = $clog2(TABLE_SIZE),
   localparam int unsigned DW = 64 + 64 + 64 + SW + LW
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);
   logic [DW-1:0] mem [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hw/rtl/call_trace_hash_aggregator_core.sv
// ----------------------------------------------------------------------------
// call_trace_hash_aggregator_core
// Folds stack frames into a hash and counts traces in a hash table.
// ----------------------------------------------------------------------------
// One request beat is one stack frame. A frame beat passes the accept cycle
// in IDLE and then states M1 to M6 for the three chained constant multiplies
// of the fold (the seed multiply of a trace's first frame overlaps them)
// through the shared multiplier, whose product is registered. Frames beyond
// STACK_DEPTH in one trace are taken in IDLE and dropped. The last frame then
// finalizes the hash (FIN1, FIN2), probes the slot memory linearly, each slot
// visited in RD and CMP (read, compare and write back), and a newly stored
// trace whose frames fit copies its n frames into the arena in the COPY state.
// A slot is read again only by a later trace, long after its write, so no
// forwarding is needed. After reset a clearing pass writes every slot, one per
// cycle, before the first beat is taken. The response sits in an output
// register; a last frame is held off while a response still waits, other
// frames are taken.
module call_trace_hash_aggregator_core #(
   parameter int unsigned TABLE_SIZE        = cth_pkg::TABLE_SIZE_DEF,
   parameter int unsigned FRAME_STORE_DEPTH = cth_pkg::FRAME_DEPTH_DEF,
   parameter int unsigned STACK_DEPTH       = cth_pkg::STACK_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cth_req_if.sink   req,
   cth_rsp_if.source rsp
);
   localparam int unsigned AW = $clog2(TABLE_SIZE);
   localparam int unsigned FW = $clog2(FRAME_STORE_DEPTH + 1);
   localparam int unsigned FA = $clog2(FRAME_STORE_DEPTH);
   localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned SW = (FA > 0) ? FA : 1;
   localparam int unsigned LW = PW;
   localparam int unsigned DW = 192 + SW + LW;
   localparam int unsigned SH = cth_pkg::MIX_SHIFT;

   typedef enum logic [3:0] {
      CLEAR, IDLE, M1, M2, M3, M4, M5, M6, FIN1, FIN2, RD, CMP, COPY
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_ff, bucket_ff, idx_ff;
   logic [63:0] hash_ff, mul_a_ff;
   logic [PW-1:0] pos_ff;
   logic [FW-1:0] fill_ff;
   logic overflow_ff;
   logic [31:0] weight_ff;
   logic last_ff;
   logic first_ff;
   logic [7:0] len_ff;
   logic [PW-1:0] cp_ff;
   logic [FW-1:0] cp_base_ff;
   logic rsp_valid_ff;
   cth_pkg::rsp_type rsp_ff;

   logic [63:0] stage_method [STACK_DEPTH];
   logic [31:0] stage_bci [STACK_DEPTH];
   logic [63:0] arena_method [FRAME_STORE_DEPTH];
   logic [31:0] arena_bci [FRAME_STORE_DEPTH];
   logic [63:0] st_m_ff;
   logic [31:0] st_b_ff;
   logic        cp_vld_ff;
   logic [FA-1:0] cp_wa_ff;

   logic [63:0] mul_p;
   logic [DW-1:0] rd_data, wr_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   logic [63:0] e_hash, e_samp, e_wgt;
   logic [SW-1:0] e_start;
   logic [LW-1:0] e_len;

   logic take;
   logic [63:0] p_mix, fin;
   logic fits;
   logic hit, vacant, wrap;
   logic [AW-1:0] idx_nx;

   cth_mul64 u_mul (.clock(clock), .a(mul_a_ff), .p(mul_p));

   cth_table #(.TABLE_SIZE(TABLE_SIZE), .SW(SW), .LW(LW)) u_table (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   assign {e_hash, e_samp, e_wgt, e_start, e_len} = rd_data;

   // Hold off a last frame while the previous response still waits.
   assign req.ready = (state_ff == IDLE) && !(req.data.last_frame && rsp_valid_ff);
   assign take = req.valid && req.ready;

   // Xor-shift of the product serves both the fold and the finalization.
   assign p_mix = mul_p ^ (mul_p >> SH);
   assign fin   = (p_mix == 64'd0) ? 64'd1 : p_mix;

   assign fits = ({1'b0, fill_ff} + {{(FW+1-PW){1'b0}}, pos_ff})
                 <= (FW+1)'(FRAME_STORE_DEPTH);

   assign hit    = (e_hash == hash_ff);
   assign vacant = (e_hash == 64'd0);
   assign idx_nx = idx_ff + AW'(1);
   assign wrap   = (idx_nx == bucket_ff);
   assign rd_addr = idx_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      if (state_ff == CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = {(clr_ff == '0) ? {64{1'b1}} : 64'd0, {(DW-64){1'b0}}};
      end else if (state_ff == CMP) begin
         if (hit) begin
            wr_en   = 1'b1;
            wr_data = {e_hash, e_samp + 64'd1, e_wgt + {32'd0, weight_ff}, e_start, e_len};
         end else if (vacant) begin
            wr_en = 1'b1;
            if (fits)
               wr_data = {hash_ff, 64'd1, {32'd0, weight_ff}, SW'(fill_ff), LW'(pos_ff)};
            else
               wr_data = {hash_ff, 64'd1, {32'd0, weight_ff}, {(SW+LW){1'b0}}};
         end
      end
   end

   // Staging buffer and arena copy path.
   always_ff @(posedge clock) begin
      if (take && (pos_ff < PW'(STACK_DEPTH))) begin
         stage_method[SA'(pos_ff)] <= req.data.frame_method;
         stage_bci[SA'(pos_ff)]    <= req.data.frame_bci;
      end
      st_m_ff <= stage_method[SA'(cp_ff)];
      st_b_ff <= stage_bci[SA'(cp_ff)];
      if (cp_vld_ff) begin
         arena_method[cp_wa_ff] <= st_m_ff;
         arena_bci[cp_wa_ff]    <= st_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cp_vld_ff    <= 1'b0;
         cp_ff        <= '0;
      end else begin
         cp_vld_ff <= (state_ff == COPY) && (cp_ff < pos_ff);
         cp_wa_ff  <= FA'(cp_base_ff + {{(FW-PW){1'b0}}, cp_ff});
         // Raise the response at the end of a probe, drop it once taken.
         if (state_ff == CMP && (hit || vacant || wrap))
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(TABLE_SIZE - 1))
                  state_ff <= IDLE;
            end
            IDLE: begin
               if (take) begin
                  weight_ff <= req.data.sample_weight;
                  last_ff   <= req.data.last_frame;
                  first_ff  <= (pos_ff == '0);
                  len_ff    <= req.data.trace_length;
                  if (pos_ff < PW'(STACK_DEPTH)) begin
                     mul_a_ff <= req.data.frame_method;
                     pos_ff   <= pos_ff + PW'(1);
                     state_ff <= M1;
                  end else if (req.data.last_frame) begin
                     // Past the depth limit: finalize the hash as it stands.
                     mul_a_ff <= hash_ff ^ (hash_ff >> SH);
                     state_ff <= FIN1;
                  end
               end
            end
            M1: begin
               // Slip the seed multiply in behind the method multiply.
               mul_a_ff <= {56'd0, len_ff};
               state_ff <= M2;
            end
            M2: begin
               mul_a_ff <= p_mix;
               state_ff <= M3;
            end
            M3: begin
               if (first_ff)
                  hash_ff <= mul_p;
               state_ff <= M4;
            end
            M4: begin
               // Third multiply of the fold: h = (h ^ k) * C.
               mul_a_ff <= hash_ff ^ mul_p;
               state_ff <= M5;
            end
            M5: state_ff <= M6;
            M6: begin
               hash_ff <= mul_p;
               if (last_ff) begin
                  mul_a_ff <= p_mix;
                  state_ff <= FIN1;
               end else begin
                  state_ff <= IDLE;
               end
            end
            FIN1: state_ff <= FIN2;
            FIN2: begin
               hash_ff   <= fin;
               idx_ff    <= AW'(fin);
               bucket_ff <= AW'(fin);
               state_ff  <= RD;
            end
            RD: state_ff <= CMP;
            CMP: begin
               if (hit) begin
                  rsp_ff   <= '{trace_slot: 12'(idx_ff), new_entry: 1'b0,
                                frames_dropped: 1'b0, table_full: 1'b0};
                  pos_ff   <= '0;
                  state_ff <= IDLE;
               end else if (vacant) begin
                  rsp_ff <= '{trace_slot: 12'(idx_ff), new_entry: 1'b1,
                              frames_dropped: !fits, table_full: 1'b0};
                  if (fits) begin
                     cp_base_ff <= fill_ff;
                     fill_ff    <= fill_ff + {{(FW-PW){1'b0}}, pos_ff};
                     state_ff   <= COPY;
                  end else begin
                     overflow_ff <= 1'b1;
                     pos_ff      <= '0;
                     state_ff    <= IDLE;
                  end
               end else if (wrap) begin
                  rsp_ff   <= '{trace_slot: 12'd0, new_entry: 1'b0,
                                frames_dropped: 1'b0, table_full: 1'b1};
                  pos_ff   <= '0;
                  state_ff <= IDLE;
               end else begin
                  idx_ff   <= idx_nx;
                  state_ff <= RD;
               end
            end
            COPY: begin
               if (cp_ff == pos_ff) begin
                  pos_ff   <= '0;
                  cp_ff    <= '0;
                  state_ff <= IDLE;
               end else begin
                  cp_ff <= cp_ff + PW'(1);
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;
endmodule

FILE: hw/rtl/cth_checker.sv
// ----------------------------------------------------------------------------
// cth_checker
// Port-level checks of the aggregator, bound to the top level.
// ----------------------------------------------------------------------------
module cth_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cth_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");
   a_full_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         rsp_data.trace_slot == 12'd0 && !rsp_data.new_entry)
      else $error("full table response not slot 0");
   a_drop_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frames_dropped |-> rsp_data.new_entry)
      else $error("frames dropped without new entry");
   a_no_ready_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during clearing pass");
endmodule

bind call_trace_hash_aggregator_core cth_checker u_cth_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

FILE: test/cth_tb_if.sv
// ----------------------------------------------------------------------------
// cth_tb_if
// Per-beat stimulus record shared by the bench.
// ----------------------------------------------------------------------------
// The channel interfaces are defined with the RTL (cth_req_if, cth_rsp_if).
// This file only holds the per-beat stimulus record shared by the bench.
package cth_tb_pkg;

   typedef struct {
      cth_pkg::req_type beat;
      int               idle_pct;
      int               stall_pct;
   } frame_item_type;

endpackage

FILE: test/tb_call_trace_hash_aggregator_core.sv
// ----------------------------------------------------------------------------
// tb_call_trace_hash_aggregator_core
// Self-checking bench for the call trace hash aggregator.
// ----------------------------------------------------------------------------
// Frames are queued by an initial block and sent by a clocked driver. Every
// accepted frame is given to a local hash/table model; each last frame
// yields one expected response that the monitor checks field by field.
// Hashes for selected traces are built backwards through the mix so that the
// zero hash and the all-ones hash are reached directly.
module tb_call_trace_hash_aggregator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TBL_SLOTS   = cth_pkg::TABLE_SIZE_DEF;
   localparam int ARENA_DEPTH = cth_pkg::FRAME_DEPTH_DEF;
   localparam int DEPTH_CAP   = cth_pkg::STACK_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cth_req_if req_ch();
   cth_rsp_if rsp_ch();

   call_trace_hash_aggregator_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // pending frames, expected responses, and the model's own state
   cth_tb_pkg::frame_item_type pending_frames[$];
   cth_pkg::rsp_type            expected_slots[$];
   logic [63:0] tbl_hash[TBL_SLOTS];
   int          arena_used;
   logic [63:0] trace_hash;
   int          staged_frames;
   logic [63:0] mix_inv;
   int          stall_pct;
   int          error_count;
   int          cycle_count;

   // ------------------------------------------------------------------------
   // hash arithmetic
   // ------------------------------------------------------------------------
   function automatic logic [63:0] fold_method(logic [63:0] h, logic [63:0] m);
      logic [63:0] k;
      k = m * cth_pkg::MIX_MUL;
      k = k ^ (k >> cth_pkg::MIX_SHIFT);
      k = k * cth_pkg::MIX_MUL;
      return (h ^ k) * cth_pkg::MIX_MUL;
   endfunction

   function automatic logic [63:0] finalize_hash(logic [63:0] h);
      h = h ^ (h >> cth_pkg::MIX_SHIFT);
      h = h * cth_pkg::MIX_MUL;
      h = h ^ (h >> cth_pkg::MIX_SHIFT);
      return (h == 64'd0) ? 64'd1 : h;
   endfunction

   // Invert the mix: return the method id whose one-frame trace of the given
   // length field finalizes to target (before the zero repair). A right xor
   // shift by 47 is its own inverse on 64 bits.
   function automatic logic [63:0] method_for_hash(logic [63:0] target,
                                                   logic [7:0] len);
      logic [63:0] r;
      logic [63:0] k;
      r = target ^ (target >> cth_pkg::MIX_SHIFT);
      r = r * mix_inv;
      r = r ^ (r >> cth_pkg::MIX_SHIFT);
      k = (r * mix_inv) ^ (64'(len) * cth_pkg::MIX_MUL);
      k = k * mix_inv;
      k = k ^ (k >> cth_pkg::MIX_SHIFT);
      return k * mix_inv;
   endfunction

   // ------------------------------------------------------------------------
   // model: fold one accepted frame, probe the table on the last one
   // ------------------------------------------------------------------------
   function automatic void predict_frame(cth_pkg::req_type f);
      cth_pkg::rsp_type r;
      logic [63:0]      h;
      int               n;
      int               bucket;
      int               idx;
      if (staged_frames == 0) trace_hash = 64'(f.trace_length) * cth_pkg::MIX_MUL;
      if (staged_frames < DEPTH_CAP) begin
         trace_hash = fold_method(trace_hash, f.frame_method);
         staged_frames++;
      end
      if (!f.last_frame) return;
      n = staged_frames;
      h = finalize_hash(trace_hash);
      staged_frames = 0;
      trace_hash = '0;
      r = '0;
      bucket = int'(h[11:0]) & (TBL_SLOTS - 1);
      idx = bucket;
      forever begin
         if (tbl_hash[idx] == h) break;
         if (tbl_hash[idx] == 64'd0) begin
            tbl_hash[idx] = h;
            r.new_entry = 1'b1;
            if (arena_used + n > ARENA_DEPTH) r.frames_dropped = 1'b1;
            else arena_used += n;
            break;
         end
         idx = (idx + 1) & (TBL_SLOTS - 1);
         if (idx == bucket) begin
            r.table_full = 1'b1;
            idx = 0;
            break;
         end
      end
      r.trace_slot = 12'(idx);
      expected_slots.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------------
   task automatic queue_frame(logic [7:0] len, logic [63:0] m, logic last,
                              int idle, int stall);
      cth_tb_pkg::frame_item_type it;
      it.beat.trace_length  = len;
      it.beat.frame_method  = m;
      it.beat.frame_bci     = $signed($urandom());
      it.beat.sample_weight = $urandom();
      it.beat.last_frame    = last;
      it.idle_pct  = idle;
      it.stall_pct = stall;
      pending_frames.push_back(it);
   endtask

   task automatic queue_trace(logic [63:0] methods[$], logic [7:0] len,
                              int idle, int stall);
      foreach (methods[i]) queue_frame(len, methods[i], i == methods.size() - 1,
                                       idle, stall);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // ------------------------------------------------------------------------
   // driver: hold a beat until taken, then advance or idle
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_frame(req_ch.data);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_frames.size() > 0 &&
                $urandom_range(99) >= pending_frames[0].idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.data  <= pending_frames[0].beat;
               stall_pct    <= pending_frames[0].stall_pct;
               void'(pending_frames.pop_front());
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: stall at random, check each response beat against the model
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_slots.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %p",
                        $realtime, rsp_ch.data);
               error_count++;
            end else begin
               if (rsp_ch.data.trace_slot !== expected_slots[0].trace_slot) begin
                  $display("%0t: trace_slot expected %0d actual %0d", $realtime,
                           expected_slots[0].trace_slot, rsp_ch.data.trace_slot);
                  error_count++;
               end
               if (rsp_ch.data.new_entry !== expected_slots[0].new_entry) begin
                  $display("%0t: new_entry expected %0b actual %0b", $realtime,
                           expected_slots[0].new_entry, rsp_ch.data.new_entry);
                  error_count++;
               end
               if (rsp_ch.data.frames_dropped !== expected_slots[0].frames_dropped) begin
                  $display("%0t: frames_dropped expected %0b actual %0b", $realtime,
                           expected_slots[0].frames_dropped,
                           rsp_ch.data.frames_dropped);
                  error_count++;
               end
               if (rsp_ch.data.table_full !== expected_slots[0].table_full) begin
                  $display("%0t: table_full expected %0b actual %0b", $realtime,
                           expected_slots[0].table_full, rsp_ch.data.table_full);
                  error_count++;
               end
               void'(expected_slots.pop_front());
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      logic [63:0] trace_frames[$];
      logic [63:0] replay_pool[$][$];
      logic [7:0]  replay_len[$];
      int          idle_tbl[4];
      int          stall_tbl[4];
      int          frames_sent;
      int          ph;
      int          len;
      int          pick;
      logic [7:0]  len_field;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      stall_pct    = 0;
      error_count  = 0;
      cycle_count  = 0;
      arena_used   = 0;
      trace_hash   = '0;
      staged_frames = 0;
      foreach (tbl_hash[i]) tbl_hash[i] = '0;
      tbl_hash[0] = '1;

      // Newton iteration for the inverse of the odd multiplier mod 2^64
      mix_inv = cth_pkg::MIX_MUL;
      repeat (6) mix_inv = mix_inv * (64'd2 - cth_pkg::MIX_MUL * mix_inv);

      // directed: zero hash repaired to 1, all-ones hash (the value of reserved slot 0) stored at slot 4095
      queue_frame(8'd1, method_for_hash(64'd0, 8'd1), 1'b1, 0, 0);
      queue_frame(8'd1, method_for_hash(64'd0, 8'd1), 1'b1, 0, 0);
      queue_frame(8'd3, method_for_hash('1, 8'd3), 1'b1, 0, 0);
      // field extremes in short traces
      queue_frame(8'd1, 64'd0, 1'b0, 0, 0);
      queue_frame(8'd128, '1, 1'b1, 0, 0);
      begin
         cth_tb_pkg::frame_item_type it;
         it.beat = '{frame_method: '1, frame_bci: 32'sh7fffffff,
                     sample_weight: '1, trace_length: 8'd128, last_frame: 1'b1};
         it.idle_pct = 0; it.stall_pct = 0;
         pending_frames.push_back(it);
         it.beat.frame_bci = 32'sh80000000;
         it.beat.sample_weight = '0;
         it.beat.frame_method = 64'd0;
         it.beat.trace_length = 8'd1;
         pending_frames.push_back(it);
      end
      // length mismatch: field says 5, three frames sent; repeat to hit found
      trace_frames = '{64'd11, 64'd22, 64'd33};
      repeat (2) queue_trace(trace_frames, 8'd5, 0, 0);
      // too many frames: 130 frames of a trace, the tail ignored
      trace_frames.delete();
      repeat (130) trace_frames.push_back(rand64());
      queue_trace(trace_frames, 8'd128, 0, 0);

      // random traces across idle and stall phases
      idle_tbl  = '{0, 69, 0, 31};
      stall_tbl = '{0, 0, 69, 31};
      frames_sent = 0;
      while (frames_sent < 1750) begin
         ph = (frames_sent / 240) % 4;
         trace_frames.delete();
         if (replay_pool.size() > 0 && $urandom_range(99) < 40) begin
            pick = $urandom_range(replay_pool.size() - 1);
            trace_frames = replay_pool[pick];
            len_field = replay_len[pick];
         end else if ($urandom_range(99) < 8) begin
            // broken trace: bad length field, sometimes overlong
            len = $urandom_range(140, 1);
            repeat (len) trace_frames.push_back(rand64());
            len_field = 8'($urandom_range(128, 1));
         end else begin
            len = ($urandom_range(99) < 5) ? $urandom_range(128, 1)
                                           : $urandom_range(8, 1);
            repeat (len) begin
               // small id pool so method ids repeat across traces
               if ($urandom_range(1)) trace_frames.push_back(64'($urandom_range(15)));
               else trace_frames.push_back(rand64());
            end
            len_field = 8'(len);
            replay_pool.push_back(trace_frames);
            replay_len.push_back(len_field);
         end
         queue_trace(trace_frames, len_field, idle_tbl[ph], stall_tbl[ph]);
         frames_sent += trace_frames.size();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (pending_frames.size() == 0);
      @(posedge clock);
      while (req_ch.valid) @(posedge clock);
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
